// ===== rtl/ssd_pkg.sv =====
package ssd_pkg;

  localparam int unsigned ThrW     = 16;
  localparam int unsigned SampW    = 20;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned ProbW    = 16;
  localparam int unsigned ValidW   = 10;
  localparam int unsigned CntW     = 16;
  localparam int unsigned OutW     = 32;

  localparam logic [CntW-1:0] CountMax = '1;

  localparam logic [ThrW-1:0]  ThresholdReset  = 16'd19661;
  localparam logic [SampW-1:0] MinSilenceReset = 20'd1600;
  localparam logic [SampW-1:0] MinSpeechReset  = 20'd4000;
  localparam logic [SampW-1:0] PadReset        = 20'd480;

  typedef enum logic [CfgIdxW-1:0] {
    REG_THRESHOLD   = 2'd0,
    REG_MIN_SILENCE = 2'd1,
    REG_MIN_SPEECH  = 2'd2,
    REG_PAD         = 2'd3
  } cfg_reg_e;

endpackage

// ===== rtl/speech_segment_detector_top.sv =====
// Channel  Direction  Handshake              Payload
// cfg      in         cfg_we_i               cfg_index_i, cfg_data_i
// in       in         in_valid_i/in_stall_o  speech_prob_i, valid_samples_i, last_chunk_i
// out      out        out_valid_o/out_stall_i seg_start_o, seg_end_o, at_stream_end_o
//
// One chunk beat is accepted per cycle unless stalled; its segment beat is registered.
// The segment state loop updates from the input register and the state registers.
// A chunk that closes no segment passes even while the output register is stalled.
// Reset restores the register defaults and starts a new stream at sample zero.
// After a last chunk all segment state returns to zero and the next chunk starts a new stream.
module speech_segment_detector_top #(
  parameter int unsigned CHUNK_SAMPLES = 640,
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ssd_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [ssd_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [ssd_pkg::ProbW-1:0]        speech_prob_i,
  input  logic [ssd_pkg::ValidW-1:0]       valid_samples_i,
  input  logic                             last_chunk_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [ssd_pkg::OutW-1:0]         seg_start_o,
  output logic [ssd_pkg::OutW-1:0]         seg_end_o,
  output logic                             at_stream_end_o
);

  localparam int unsigned ChunkW = $clog2(CHUNK_SAMPLES + 1);
  localparam int unsigned VW     = (ChunkW > ssd_pkg::ValidW) ? ChunkW : ssd_pkg::ValidW;
  localparam int unsigned WW     =
    ((POSITION_BITS > ssd_pkg::SampW) ? POSITION_BITS : ssd_pkg::SampW) + 1;
  localparam int unsigned PW     = ssd_pkg::CntW + ChunkW;
  localparam int unsigned PB     = POSITION_BITS;

  logic [ssd_pkg::ThrW-1:0]  thr_q;
  logic [ssd_pkg::SampW-1:0] min_sil_q;
  logic [ssd_pkg::SampW-1:0] min_speech_q;
  logic [ssd_pkg::SampW-1:0] pad_q;

  logic                       s1_v_q;
  logic [ssd_pkg::ProbW-1:0]  s1_prob_q;
  logic [ssd_pkg::ValidW-1:0] s1_valid_q;
  logic                       s1_last_q;

  logic                       in_speech_q;
  logic [PB-1:0]              open_q;
  logic [PB-1:0]              sb_q;
  logic [ssd_pkg::CntW-1:0]   cnt_q;
  logic [PB-1:0]              cp_q;
  logic [PB-1:0]              seen_q;

  logic                       out_v_q;
  logic [ssd_pkg::OutW-1:0]   out_start_q;
  logic [ssd_pkg::OutW-1:0]   out_end_q;
  logic                       out_flag_q;

  logic                       in_accept;
  logic                       out_free;
  logic                       process;

  logic [VW-1:0]              valid_ext;
  logic [VW-1:0]              valid_clip;
  logic [PB-1:0]              seen_new;
  logic                       speech;
  logic [PB-1:0]              open_calc;
  logic [PB-1:0]              sb_sel;
  logic [ssd_pkg::CntW-1:0]   cnt_inc;
  logic [PW-1:0]              sil_len;
  logic [WW-1:0]              end_sum;
  logic [PB-1:0]              end_val;
  logic [PB-1:0]              len;

  logic                       in_speech_n;
  logic [PB-1:0]              open_n;
  logic [PB-1:0]              sb_n;
  logic [ssd_pkg::CntW-1:0]   cnt_n;
  logic                       has_res;
  logic [PB-1:0]              res_start;
  logic [PB-1:0]              res_end;
  logic                       res_flag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        <= ssd_pkg::ThresholdReset;
      min_sil_q    <= ssd_pkg::MinSilenceReset;
      min_speech_q <= ssd_pkg::MinSpeechReset;
      pad_q        <= ssd_pkg::PadReset;
    end else if (cfg_we_i) begin
      unique case (ssd_pkg::cfg_reg_e'(cfg_index_i))
        ssd_pkg::REG_THRESHOLD:   thr_q        <= cfg_data_i[ssd_pkg::ThrW-1:0];
        ssd_pkg::REG_MIN_SILENCE: min_sil_q    <= cfg_data_i;
        ssd_pkg::REG_MIN_SPEECH:  min_speech_q <= cfg_data_i;
        ssd_pkg::REG_PAD:         pad_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_free   = !out_v_q || !out_stall_i;
  assign process    = s1_v_q && (!has_res || out_free);
  assign in_stall_o = s1_v_q && !process;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    valid_ext  = VW'(s1_valid_q);
    valid_clip = (valid_ext > VW'(CHUNK_SAMPLES)) ? VW'(CHUNK_SAMPLES) : valid_ext;
    seen_new   = seen_q + PB'(valid_clip);
    speech     = s1_prob_q >= thr_q;
    open_calc  = (WW'(cp_q) > WW'(pad_q)) ? PB'(WW'(cp_q) - WW'(pad_q)) : '0;
    sb_sel     = (cnt_q == '0) ? cp_q : sb_q;
    cnt_inc    = (cnt_q == ssd_pkg::CountMax) ? cnt_q : cnt_q + ssd_pkg::CntW'(1);
    sil_len    = PW'(cnt_inc) * PW'(CHUNK_SAMPLES);
    end_sum    = WW'(sb_sel) + WW'(pad_q);
    end_val    = (end_sum > WW'(seen_new)) ? seen_new : PB'(end_sum);

    in_speech_n = in_speech_q;
    open_n      = open_q;
    sb_n        = sb_q;
    cnt_n       = cnt_q;
    has_res     = 1'b0;
    res_start   = open_q;
    res_end     = end_val;
    res_flag    = 1'b0;

    if (speech) begin
      cnt_n = '0;
      if (!in_speech_q) begin
        open_n      = open_calc;
        in_speech_n = 1'b1;
      end
    end else if (in_speech_q) begin
      sb_n  = sb_sel;
      cnt_n = cnt_inc;
      if (sil_len >= PW'(min_sil_q)) begin
        has_res     = 1'b1;
        in_speech_n = 1'b0;
        cnt_n       = '0;
      end
    end

    len = (seen_new > open_n) ? seen_new - open_n : '0;
    if (s1_last_q && in_speech_n && (WW'(len) >= WW'(min_speech_q))) begin
      has_res   = 1'b1;
      res_start = open_n;
      res_end   = seen_new;
      res_flag  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_accept) begin
      s1_v_q <= 1'b1;
    end else if (process) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_prob_q  <= speech_prob_i;
      s1_valid_q <= valid_samples_i;
      s1_last_q  <= last_chunk_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_speech_q <= 1'b0;
      open_q      <= '0;
      sb_q        <= '0;
      cnt_q       <= '0;
      cp_q        <= '0;
      seen_q      <= '0;
    end else if (process) begin
      if (s1_last_q) begin
        in_speech_q <= 1'b0;
        open_q      <= '0;
        sb_q        <= '0;
        cnt_q       <= '0;
        cp_q        <= '0;
        seen_q      <= '0;
      end else begin
        in_speech_q <= in_speech_n;
        open_q      <= open_n;
        sb_q        <= sb_n;
        cnt_q       <= cnt_n;
        cp_q        <= cp_q + PB'(CHUNK_SAMPLES);
        seen_q      <= seen_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (process && has_res) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process && has_res) begin
      out_start_q <= ssd_pkg::OutW'(res_start);
      out_end_q   <= ssd_pkg::OutW'(res_end);
      out_flag_q  <= res_flag;
    end
  end

  assign out_valid_o     = out_v_q;
  assign seg_start_o     = out_start_q;
  assign seg_end_o       = out_end_q;
  assign at_stream_end_o = out_flag_q;

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_v_q)
    else $error("Input stalled with an empty input register.");

  a_silence_in_speech: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> in_speech_q)
    else $error("Silence run counted outside a segment.");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && s1_last_q) |=> (!in_speech_q && seen_q == '0 && cp_q == '0))
    else $error("Stream state not cleared after the last chunk.");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && has_res) |-> out_free)
    else $error("Segment produced while the output register was occupied.");

endmodule
